>>> rtl/core/packed_10bit_line_unpacker_assert.svh
// Assertion macros used by the checker file of the line unpacker.
`ifndef PACKED_10BIT_LINE_UNPACKER_ASSERT_SVH
`define PACKED_10BIT_LINE_UNPACKER_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define PLU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line unpacker check failed");

// Next-cycle implication, ignored while reset is held.
`define PLU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line unpacker check failed");

// Next-cycle implication that also holds across reset.
`define PLU_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("line unpacker check failed");

`endif

>>> rtl/core/plu_pkg.sv
// Types and constants shared by the packed 10-bit line unpacker.
package plu_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int BUF_BITS    = SAMPLE_BITS + 7;
  localparam int CNT_BITS    = 5;
  localparam int COL_BITS    = 14;
  localparam int LW_BITS     = 15;
  localparam int SC_BITS     = 15;
  localparam int SHIFT_BITS  = 14;
  localparam int LINE_BITS   = 16;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [COL_BITS-1:0] COLUMN_MAX = '1;
  localparam logic [LW_BITS-1:0]  LW_RESET   = 15'd3712;
  localparam logic [LW_BITS-1:0]  SPL_RESET  = 15'd3712;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIANCE_MODE    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPLIT_LINE       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOWER_SHIFT      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_SHIFT      = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_WIDTH       = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLES_PER_LINE = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAD_GAIN         = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAD_BIAS         = 3'd7;

  typedef struct packed {
    logic                   radiance_mode;
    logic [LINE_BITS-1:0]   split_line;
    logic [SHIFT_BITS-1:0]  lower_shift;
    logic [SHIFT_BITS-1:0]  upper_shift;
    logic [LW_BITS-1:0]     line_width;
    logic [SC_BITS-1:0]     samples_per_line;
    logic signed [31:0]     rad_gain;
    logic signed [31:0]     rad_bias;
  } plu_cfg_t;

  typedef struct packed {
    logic                   emit;
    logic [SAMPLE_BITS-1:0] sample;
    logic [COL_BITS-1:0]    column;
    logic                   column_bad;
    logic                   end_of_line;
  } plu_smp_t;

endpackage

>>> rtl/core/plu_aligner.sv
// Bit aligner, sample counter and mirrored column calculation.
module plu_aligner
  import plu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  plu_cfg_t             cfg,
  input  logic                 accept,
  input  logic [7:0]           payload_byte,
  input  logic                 line_first,
  input  logic [LINE_BITS-1:0] line_index,
  output plu_smp_t             smp
);

  logic [BUF_BITS-1:0] buf_r, buf_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [SC_BITS-1:0]  sc_r, sc_nxt;

  logic [BUF_BITS-1:0] base_buf, fill_buf, keep_mask, shifted;
  logic [CNT_BITS-1:0] base_cnt, fill_cnt, rem_cnt;
  logic [CNT_BITS:0]   sum_cnt;
  logic [SC_BITS-1:0]  base_sc, inc_sc;
  logic [SHIFT_BITS-1:0] shift;
  logic signed [16:0]  col;
  logic                full, bad;

  always_comb begin
    // Clear the aligner at the start of a line
    base_buf = line_first ? '0 : buf_r;
    base_cnt = line_first ? '0 : cnt_r;
    base_sc  = line_first ? '0 : sc_r;
    full     = base_sc >= cfg.samples_per_line;

    // Take the byte in, keeping only the newest bits
    fill_buf = {base_buf[BUF_BITS-9:0], payload_byte};
    sum_cnt  = {1'b0, base_cnt} + (CNT_BITS+1)'(8);
    fill_cnt = (sum_cnt > (CNT_BITS+1)'(BUF_BITS)) ? CNT_BITS'(BUF_BITS)
                                                   : sum_cnt[CNT_BITS-1:0];

    // Cut one sample off the top of the pending bits
    rem_cnt   = fill_cnt - CNT_BITS'(SAMPLE_BITS);
    shifted   = fill_buf >> rem_cnt;
    keep_mask = ~({BUF_BITS{1'b1}} << rem_cnt);
    inc_sc    = base_sc + SC_BITS'(1);

    // Mirrored column, shift only in raw mode
    if (cfg.radiance_mode) begin
      shift = '0;
    end else if (line_index < cfg.split_line) begin
      shift = cfg.lower_shift;
    end else begin
      shift = cfg.upper_shift;
    end
    col = $signed({2'b00, cfg.line_width}) - 17'sd1 - $signed({2'b00, base_sc})
        - $signed({3'b000, shift});
    bad = col[16] || (col[15:0] >= {1'b0, cfg.line_width})
        || (col[15:0] > {2'b00, COLUMN_MAX});

    smp.emit        = !full && (fill_cnt >= CNT_BITS'(SAMPLE_BITS));
    smp.sample      = shifted[SAMPLE_BITS-1:0];
    smp.column      = bad ? '0 : col[COL_BITS-1:0];
    smp.column_bad  = bad;
    smp.end_of_line = inc_sc == cfg.samples_per_line;

    // Next state
    if (full) begin
      buf_nxt = base_buf;
      cnt_nxt = base_cnt;
      sc_nxt  = base_sc;
    end else if (smp.emit) begin
      buf_nxt = fill_buf & keep_mask;
      cnt_nxt = rem_cnt;
      sc_nxt  = inc_sc;
    end else begin
      buf_nxt = fill_buf;
      cnt_nxt = fill_cnt;
      sc_nxt  = base_sc;
    end
  end

  // Advance the aligner state on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r <= '0;
      cnt_r <= '0;
      sc_r  <= '0;
    end else if (accept) begin
      buf_r <= buf_nxt;
      cnt_r <= cnt_nxt;
      sc_r  <= sc_nxt;
    end
  end

endmodule

>>> rtl/core/plu_calib.sv
// Radiance calibration: registered multiply, then round, offset and saturate.
module plu_calib
  import plu_pkg::*;
(
  input  logic                   clk,
  input  logic                   load,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic signed [31:0]     rad_gain,
  input  logic signed [31:0]     rad_bias,
  output logic signed [31:0]     radiance
);

  logic signed [42:0] prod_r;
  logic signed [43:0] rnd;
  logic signed [31:0] q;
  logic signed [33:0] sum;

  // Hold the product of sample and slope (Q.28)
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= $signed({1'b0, sample}) * rad_gain;
    end
  end

  // Round to Q16.16, ties upward, add offset and saturate
  always_comb begin
    rnd = {prod_r[42], prod_r} + 44'sd2048;
    q   = rnd[43:12];
    sum = {{2{q[31]}}, q} + {{2{rad_bias[31]}}, rad_bias};
    if ((sum[33:31] == 3'b000) || (sum[33:31] == 3'b111)) begin
      radiance = sum[31:0];
    end else if (sum[33]) begin
      radiance = 32'sh8000_0000;
    end else begin
      radiance = 32'sh7FFF_FFFF;
    end
  end

endmodule

>>> rtl/core/packed_10bit_line_unpacker.sv
// Top level of the packed 10-bit line unpacker.
// A sample is registered in s1_r, then s2_r, then the output registers.
// Throughput: one byte per cycle unless out_ready stalls; aligner next state is combinational.
// The calibration multiply has its own stage; each stage stalls only when its successor is full.
// Reset (rst_n low, synchronous) empties the pipeline, clears the aligner and loads the
// register defaults (line width and samples per line 3712, all else zero).
module packed_10bit_line_unpacker
  import plu_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_payload_byte,
  input  logic                       in_line_first,
  input  logic [15:0]                in_line_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [13:0]                out_column,
  output logic                       out_column_bad,
  output logic [9:0]                 out_raw_sample,
  output logic signed [31:0]         out_radiance,
  output logic                       out_end_of_line,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [31:0]                cfg_data
);

  plu_cfg_t cfg_r;
  plu_smp_t smp;
  plu_smp_t s1_r, s2_r;
  logic     s1_v_r, s2_v_r, out_v_r;
  logic     en_out, en2, en1, accept;
  logic signed [31:0] rad;

  logic [COL_BITS-1:0]    out_column_r;
  logic                   out_column_bad_r;
  logic [SAMPLE_BITS-1:0] out_raw_sample_r;
  logic signed [31:0]     out_radiance_r;
  logic                   out_end_of_line_r;

  // Stage enables: a stage moves when its successor is empty or moving
  assign en_out   = !out_v_r || out_ready;
  assign en2      = !s2_v_r || en_out;
  assign en1      = !s1_v_r || en2;
  assign in_ready = en1;
  assign accept   = in_valid && en1;
  assign cfg_ready = 1'b1;

  // Register file writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radiance_mode    <= 1'b0;
      cfg_r.split_line       <= '0;
      cfg_r.lower_shift      <= '0;
      cfg_r.upper_shift      <= '0;
      cfg_r.line_width       <= LW_RESET;
      cfg_r.samples_per_line <= SPL_RESET;
      cfg_r.rad_gain         <= '0;
      cfg_r.rad_bias         <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RADIANCE_MODE:    cfg_r.radiance_mode    <= cfg_data[0];
        REG_SPLIT_LINE:       cfg_r.split_line       <= cfg_data[LINE_BITS-1:0];
        REG_LOWER_SHIFT:      cfg_r.lower_shift      <= cfg_data[SHIFT_BITS-1:0];
        REG_UPPER_SHIFT:      cfg_r.upper_shift      <= cfg_data[SHIFT_BITS-1:0];
        REG_LINE_WIDTH:       cfg_r.line_width       <= cfg_data[LW_BITS-1:0];
        REG_SAMPLES_PER_LINE: cfg_r.samples_per_line <= cfg_data[SC_BITS-1:0];
        REG_RAD_GAIN:         cfg_r.rad_gain         <= cfg_data;
        REG_RAD_BIAS:         cfg_r.rad_bias         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  plu_aligner u_aligner (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .accept       (accept),
    .payload_byte (in_payload_byte),
    .line_first   (in_line_first),
    .line_index   (in_line_index),
    .smp          (smp)
  );

  plu_calib u_calib (
    .clk      (clk),
    .load     (en2 && s1_v_r),
    .sample   (s1_r.sample),
    .rad_gain (cfg_r.rad_gain),
    .rad_bias (cfg_r.rad_bias),
    .radiance (rad)
  );

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1) begin
        s1_v_r <= accept && smp.emit;
      end
      if (en2) begin
        s2_v_r <= s1_v_r;
      end
      if (en_out) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // Sample payload through the stages
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_r <= smp;
    end
    if (en2) begin
      s2_r <= s1_r;
    end
    if (en_out && s2_v_r) begin
      out_column_r      <= s2_r.column;
      out_column_bad_r  <= s2_r.column_bad;
      out_raw_sample_r  <= s2_r.sample;
      out_radiance_r    <= cfg_r.radiance_mode ? rad : 32'sd0;
      out_end_of_line_r <= s2_r.end_of_line;
    end
  end

  assign out_valid       = out_v_r;
  assign out_column      = out_column_r;
  assign out_column_bad  = out_column_bad_r;
  assign out_raw_sample  = out_raw_sample_r;
  assign out_radiance    = out_radiance_r;
  assign out_end_of_line = out_end_of_line_r;

endmodule

>>> rtl/core/plu_checker.sv
// Port-level checker for the line unpacker and its bind to the top level.
`include "packed_10bit_line_unpacker_assert.svh"

module plu_checker
  import plu_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [7:0]              in_payload_byte,
  input logic                    in_line_first,
  input logic [15:0]             in_line_index,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [13:0]             out_column,
  input logic                    out_column_bad,
  input logic [9:0]              out_raw_sample,
  input logic signed [31:0]      out_radiance,
  input logic                    out_end_of_line,
  input logic                    cfg_valid,
  input logic                    cfg_ready,
  input logic [CFG_IDX_BITS-1:0] cfg_index,
  input logic [31:0]             cfg_data
);

  // A stalled result holds
  `PLU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_raw_sample) && $stable(out_column) && $stable(out_radiance))

  // A bad column is reported as column zero
  `PLU_ASSERT_NOW(a_bad_col_zero, clk, rst_n, out_valid && out_column_bad, out_column == 14'd0)

  // Reset leaves no result pending
  `PLU_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, !rst_n, !out_valid)

  // Register writes are never refused
  `PLU_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind packed_10bit_line_unpacker plu_checker u_plu_checker (.*);

>>> verif/tb_top.sv
// Self-checking testbench for the packed 10-bit line unpacker.
`timescale 1ns / 1ps

module tb_top;
  import plu_pkg::*;

  typedef struct packed {
    logic [7:0]  payload;
    logic        is_first;
    logic [15:0] line_index;
  } beat_t;

  typedef struct packed {
    logic [13:0] column;
    logic        column_bad;
    logic [9:0]  raw_sample;
    logic [31:0] radiance;
    logic        end_of_line;
  } sample_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [7:0]              in_payload_byte = '0;
  logic                    in_line_first = 1'b0;
  logic [15:0]             in_line_index = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [13:0]             out_column;
  logic                    out_column_bad;
  logic [9:0]              out_raw_sample;
  logic signed [31:0]      out_radiance;
  logic                    out_end_of_line;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0]             cfg_data = '0;

  packed_10bit_line_unpacker dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_payload_byte (in_payload_byte),
    .in_line_first   (in_line_first),
    .in_line_index   (in_line_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_column      (out_column),
    .out_column_bad  (out_column_bad),
    .out_raw_sample  (out_raw_sample),
    .out_radiance    (out_radiance),
    .out_end_of_line (out_end_of_line),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Byte stream still to be offered, and samples still owed by the block
  beat_t     byte_feed_q[$];
  sample_t   sample_exp_q[$];
  int        bytes_queued = 0;
  int        bytes_taken = 0;
  int        err_count = 0;
  bit        idle_on = 1'b1;
  logic      in_xfer = 1'b0;
  int        in_gap = 0;
  int        out_gap = 0;
  beat_t     next_beat;
  sample_t   got_sample;
  sample_t   want_sample;

  // Shadow registers and aligner state
  plu_cfg_t    regs_shadow;
  logic [16:0] pend_bits;
  int          pend_cnt;
  int          line_samples;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Calibrated value: round the Q.28 product to Q16.16, add offset, saturate
  function automatic logic [31:0] radiance_of(logic [9:0] smp);
    longint prod;
    longint acc;
    prod = longint'(smp) * longint'($signed(regs_shadow.rad_gain));
    acc = ((prod + 64'sd2048) >>> 12) + longint'($signed(regs_shadow.rad_bias));
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[31:0];
  endfunction

  // Advance the aligner by one byte and record the sample it releases, if any
  task automatic unpack_predict(input beat_t b);
    logic [9:0]  smp;
    logic [13:0] shift;
    int          col;
    bit          bad;
    sample_t     s;
    if (b.is_first) begin
      pend_bits = '0;
      pend_cnt = 0;
      line_samples = 0;
    end
    if (line_samples >= int'(regs_shadow.samples_per_line)) return;
    pend_bits = {pend_bits[8:0], b.payload};
    pend_cnt += 8;
    if (pend_cnt > 17) pend_cnt = 17;
    if (pend_cnt < 10) return;
    pend_cnt -= 10;
    smp = 10'(pend_bits >> pend_cnt);
    pend_bits &= (17'd1 << pend_cnt) - 17'd1;
    if (regs_shadow.radiance_mode) shift = '0;
    else if (b.line_index < regs_shadow.split_line) shift = regs_shadow.lower_shift;
    else shift = regs_shadow.upper_shift;
    col = int'(regs_shadow.line_width) - 1 - line_samples - int'(shift);
    bad = (col < 0) || (col >= int'(regs_shadow.line_width)) || (col > int'(COLUMN_MAX));
    s.column = bad ? 14'd0 : col[13:0];
    s.column_bad = bad;
    s.raw_sample = smp;
    s.radiance = regs_shadow.radiance_mode ? radiance_of(smp) : 32'd0;
    line_samples++;
    s.end_of_line = (line_samples == int'(regs_shadow.samples_per_line));
    sample_exp_q.push_back(s);
  endtask

  // Input transfers feed the predictor; output transfers are checked in order
  always @(posedge clk) begin
    if (!rst_n) begin
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        unpack_predict('{in_payload_byte, in_line_first, in_line_index});
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        got_sample = '{out_column, out_column_bad, out_raw_sample, out_radiance,
                       out_end_of_line};
        if (sample_exp_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: sample with none expected: col %0d bad %0d raw %0d rad %h eol %0d",
                     $realtime, out_column, out_column_bad, out_raw_sample, out_radiance,
                     out_end_of_line);
        end else begin
          want_sample = sample_exp_q.pop_front();
          if (got_sample !== want_sample) begin
            err_count++;
            if (err_count <= 10)
              $display("%0t: mismatch: exp col %0d bad %0d raw %0d rad %h eol %0d, got col %0d bad %0d raw %0d rad %h eol %0d",
                       $realtime, want_sample.column, want_sample.column_bad,
                       want_sample.raw_sample, want_sample.radiance,
                       want_sample.end_of_line, got_sample.column, got_sample.column_bad,
                       got_sample.raw_sample, got_sample.radiance, got_sample.end_of_line);
          end
        end
      end
    end
  end

  // Drive bytes from the feed queue, with random idle bursts between transfers
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 6);
        in_valid <= 1'b0;
      end else if (byte_feed_q.size() != 0) begin
        next_beat = byte_feed_q.pop_front();
        in_valid <= 1'b1;
        in_payload_byte <= next_beat.payload;
        in_line_first <= next_beat.is_first;
        in_line_index <= next_beat.line_index;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      out_gap = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic add_beat(input logic [7:0] p, input logic f, input logic [15:0] li);
    byte_feed_q.push_back('{p, f, li});
    bytes_queued++;
  endtask

  // Wait until every byte is taken and every sample has come out, then let the pipe settle
  task automatic drain_idle();
    while (bytes_taken != bytes_queued || sample_exp_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_RADIANCE_MODE:    regs_shadow.radiance_mode = data[0];
      REG_SPLIT_LINE:       regs_shadow.split_line = data[15:0];
      REG_LOWER_SHIFT:      regs_shadow.lower_shift = data[13:0];
      REG_UPPER_SHIFT:      regs_shadow.upper_shift = data[13:0];
      REG_LINE_WIDTH:       regs_shadow.line_width = data[14:0];
      REG_SAMPLES_PER_LINE: regs_shadow.samples_per_line = data[14:0];
      REG_RAD_GAIN:         regs_shadow.rad_gain = data;
      REG_RAD_BIAS:         regs_shadow.rad_bias = data;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic rad, input logic [15:0] split,
                              input logic [13:0] lo, input logic [13:0] hi,
                              input logic [14:0] lw, input logic [14:0] spl,
                              input logic [31:0] slope, input logic [31:0] offs);
    reg_write(REG_RADIANCE_MODE, {31'd0, rad});
    reg_write(REG_SPLIT_LINE, {16'd0, split});
    reg_write(REG_LOWER_SHIFT, {18'd0, lo});
    reg_write(REG_UPPER_SHIFT, {18'd0, hi});
    reg_write(REG_LINE_WIDTH, {17'd0, lw});
    reg_write(REG_SAMPLES_PER_LINE, {17'd0, spl});
    reg_write(REG_RAD_GAIN, slope);
    reg_write(REG_RAD_BIAS, offs);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One line: mostly complete, some cut short, some noise with random line starts
  task automatic queue_line();
    int          kind;
    int          full;
    int          nb;
    logic [15:0] li;
    kind = $urandom_range(0, 9);
    case ($urandom_range(0, 3))
      0: li = regs_shadow.split_line - 16'd1;
      1: li = regs_shadow.split_line;
      default: li = 16'($urandom);
    endcase
    full = (int'(regs_shadow.samples_per_line) * 10 + 7) / 8;
    if (full > 64 || full == 0) full = $urandom_range(1, 30);
    if (kind < 7) nb = full + $urandom_range(0, 2);
    else if (kind < 9) nb = $urandom_range(1, full);
    else nb = $urandom_range(1, 6);
    for (int i = 0; i < nb; i++)
      add_beat(8'($urandom), (kind == 9) ? 1'($urandom_range(0, 1)) : (i == 0), li);
  endtask

  initial begin
    int   phase_end;
    logic rad;
    logic [15:0] split;
    logic [13:0] lo, hi;
    logic [14:0] lw, spl;
    logic [31:0] slope, offs;

    // Shadow of the reset register values
    regs_shadow = '0;
    regs_shadow.line_width = 15'd3712;
    regs_shadow.samples_per_line = 15'd3712;
    pend_bits = '0;
    pend_cnt = 0;
    line_samples = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset defaults: all-ones samples, then a restarted line of zeros
    add_beat(8'hFF, 1'b1, 16'h0000);
    repeat (4) add_beat(8'hFF, 1'b0, 16'h0000);
    add_beat(8'h00, 1'b1, 16'hFFFF);
    add_beat(8'h00, 1'b0, 16'hFFFF);
    add_beat(8'h00, 1'b0, 16'hFFFF);
    drain_idle();

    // Radiance saturating high, short line with a byte after the line is full
    program_regs(1'b1, 16'd0, 14'd0, 14'd0, 15'd4, 15'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_beat(8'hAA, 1'b1, 16'h1234);
    add_beat(8'h55, 1'b0, 16'h1234);
    add_beat(8'hFF, 1'b0, 16'h1234);
    add_beat(8'h00, 1'b0, 16'h1234);
    add_beat(8'h00, 1'b0, 16'h1234);
    drain_idle();

    // Raw mode either side of the split line, columns running off the line
    program_regs(1'b0, 16'd100, 14'd2, 14'd16383, 15'd5, 15'd4, 32'd0, 32'd0);
    for (int i = 0; i < 5; i++) add_beat(8'h80 >> i, i == 0, 16'd99);
    for (int i = 0; i < 5; i++) add_beat(8'h01 << i, i == 0, 16'd100);
    drain_idle();

    // Random phases, the first few with forced extremes
    for (int ph = 0; bytes_queued < 1170; ph++) begin
      rad = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: split = 16'd0;
        1: split = 16'hFFFF;
        default: split = 16'($urandom);
      endcase
      lo = ($urandom_range(0, 3) == 0) ? 14'd16383 : 14'($urandom_range(0, 24));
      hi = ($urandom_range(0, 3) == 0) ? 14'd16383 : 14'($urandom_range(0, 24));
      case ($urandom_range(0, 5))
        0: lw = 15'd1;
        1: lw = 15'd16384;
        default: lw = 15'($urandom_range(1, 48));
      endcase
      case ($urandom_range(0, 5))
        0: spl = 15'd1;
        1: spl = 15'd16384;
        default: spl = 15'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 4))
        0: slope = 32'h7FFF_FFFF;
        1: slope = 32'h8000_0000;
        2: slope = $urandom;
        default: slope = $urandom_range(0, 32'h2000_0000) ^ {32{1'($urandom_range(0, 1))}};
      endcase
      case ($urandom_range(0, 3))
        0: offs = 32'h7FFF_FFFF;
        1: offs = 32'h8000_0000;
        default: offs = $urandom;
      endcase
      case (ph)
        0: program_regs(1'b1, 16'hFFFF, 14'd16383, 14'd16383, 15'd16384, 15'd16384,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF);
        1: program_regs(1'b1, 16'd0, 14'd0, 14'd0, 15'd1, 15'd0,
                        32'h8000_0000, 32'h8000_0000);
        // saturate low
        2: program_regs(1'b1, split, lo, hi, lw, spl, 32'h8000_0000, 32'h8000_0000);
        // half-way rounding ties
        3: program_regs(1'b1, split, lo, hi, lw, spl, 32'hFFFF_F800, 32'd0);
        // columns beyond the largest representable one
        4: program_regs(1'b0, split, lo, hi, 15'd32767, 15'd20, slope, offs);
        default: program_regs(rad, split, lo, hi, lw, spl, slope, offs);
      endcase
      phase_end = bytes_queued + $urandom_range(70, 110);
      while (bytes_queued < phase_end && bytes_queued < 1170) begin
        queue_line();
        idle_on = (bytes_queued < 1000);
      end
      drain_idle();
    end

    if (err_count == 0 && sample_exp_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/plu_pkg.sv
rtl/core/plu_aligner.sv
rtl/core/plu_calib.sv
rtl/core/packed_10bit_line_unpacker.sv
rtl/core/plu_checker.sv
verif/tb_top.sv
